@@ hdl/rxpc_pkg.sv @@
// package for the rolling xor packet cipher
// payload structs, opcodes, size limits and the key byte select
// no dependencies
package rxpc_pkg;

  typedef enum logic {
    OP_DECRYPT = 1'b0,
    OP_ENCRYPT = 1'b1
  } opcode_t;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned HALF_W   = 32;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned POS_W    = 3;
  localparam logic [LEN_W-1:0] MAX_PACKET = 16'd8192;

  typedef struct packed {
    opcode_t          opcode;
    logic [7:0]       data_byte;
    logic             last_byte;
    logic [LEN_W-1:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // bytes 0..3 from the running low half, bytes 4..7 from the session high half
  function automatic logic [7:0] key_byte(input logic [HALF_W-1:0] low,
                                          input logic [HALF_W-1:0] high,
                                          input logic [POS_W-1:0]  pos);
    logic [HALF_W-1:0] word;
    word = pos[2] ? high : low;
    return word[{pos[1:0], 3'b000} +: 8];
  endfunction

endpackage

@@ hdl/rxpc_in_if.sv @@
// input item channel of the rolling xor packet cipher
// depends on rxpc_pkg
interface rxpc_in_if;
  logic               valid;
  logic               ready;
  rxpc_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/rxpc_out_if.sv @@
// result item channel of the rolling xor packet cipher
// depends on rxpc_pkg
interface rxpc_out_if;
  logic                valid;
  logic                ready;
  rxpc_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/rolling_xor_packet_cipher_unit.sv @@
// rolling xor packet cipher, one byte per item, separate rx and tx running keys
// input register, then result register; throughput 1 item per cycle while the result sink does not stall
// the single xor chain per direction between the two registers sets the rate
// synchronous active-low reset clears keys, chains, positions, enable flags and valids
// depends on rxpc_pkg, rxpc_in_if, rxpc_out_if
module rolling_xor_packet_cipher_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [rxpc_pkg::KEY_W-1:0] cfg_wdata,
  rxpc_in_if.sink                    in_ch,
  rxpc_out_if.source                 out_ch
);
  import rxpc_pkg::*;

  // input register stage
  logic     in_vld_r;
  in_item_t in_item_r;

  // result register stage
  logic      out_vld_r;
  out_item_t out_item_r;

  // cipher state
  logic [HALF_W-1:0] key_hi_r;
  logic [HALF_W-1:0] rx_key_r, rx_key_nxt;
  logic [HALF_W-1:0] tx_key_r, tx_key_nxt;
  logic [7:0]        rx_chain_r, rx_chain_nxt;
  logic [7:0]        tx_chain_r, tx_chain_nxt;
  logic [POS_W-1:0]  rx_pos_r, rx_pos_nxt;
  logic [POS_W-1:0]  tx_pos_r, tx_pos_nxt;
  logic              enabled_r, enabled_nxt;
  logic              first_r, first_nxt;

  logic              advance;
  logic [7:0]        res_byte;
  logic              fits;
  logic              first_pkt;

  // the held item moves on when the result register is free or drains this cycle
  assign advance      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || advance;
  assign out_ch.valid = out_vld_r;
  assign out_ch.payload = out_item_r;

  assign fits = in_item_r.packet_length <= MAX_PACKET;

  // per-byte transform and state update for the item in the input register
  always_comb begin
    rx_key_nxt   = rx_key_r;
    tx_key_nxt   = tx_key_r;
    rx_chain_nxt = rx_chain_r;
    tx_chain_nxt = tx_chain_r;
    rx_pos_nxt   = rx_pos_r;
    tx_pos_nxt   = tx_pos_r;
    enabled_nxt  = enabled_r;
    first_nxt    = first_r;
    res_byte     = in_item_r.data_byte;
    // the first encrypt byte ever turns the cipher on and opens the pass-through packet
    first_pkt    = enabled_r ? first_r : 1'b1;

    if (in_item_r.opcode == OP_ENCRYPT) begin
      if (!enabled_r) begin
        enabled_nxt = 1'b1;
        first_nxt   = 1'b1;
      end
      if (first_pkt) begin
        // first outgoing packet passes through, key untouched
        if (in_item_r.last_byte) begin
          first_nxt    = 1'b0;
          tx_chain_nxt = '0;
          tx_pos_nxt   = '0;
        end
      end else begin
        if (fits) begin
          res_byte     = in_item_r.data_byte ^ key_byte(tx_key_r, key_hi_r, tx_pos_r)
                         ^ tx_chain_r;
          tx_chain_nxt = res_byte;
          tx_pos_nxt   = tx_pos_r + POS_W'(1);
        end
        if (in_item_r.last_byte) begin
          tx_key_nxt   = tx_key_r + HALF_W'(in_item_r.packet_length);
          tx_chain_nxt = '0;
          tx_pos_nxt   = '0;
        end
      end
    end else if (enabled_r) begin
      if (fits) begin
        res_byte     = in_item_r.data_byte ^ key_byte(rx_key_r, key_hi_r, rx_pos_r)
                       ^ rx_chain_r;
        // decrypt chains on the incoming cipher byte
        rx_chain_nxt = in_item_r.data_byte;
        rx_pos_nxt   = rx_pos_r + POS_W'(1);
      end
      if (in_item_r.last_byte) begin
        rx_key_nxt   = rx_key_r + HALF_W'(in_item_r.packet_length);
        rx_chain_nxt = '0;
        rx_pos_nxt   = '0;
      end
    end
  end

  // handshake registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r <= in_ch.payload;
    end
    if (advance) begin
      out_item_r.out_byte <= res_byte;
      out_item_r.out_last <= in_item_r.last_byte;
    end
  end

  // cipher state; key writes must only come while idle so they never meet an update, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r   <= '0;
      rx_key_r   <= '0;
      tx_key_r   <= '0;
      rx_chain_r <= '0;
      tx_chain_r <= '0;
      rx_pos_r   <= '0;
      tx_pos_r   <= '0;
      enabled_r  <= 1'b0;
      first_r    <= 1'b0;
    end else if (cfg_we) begin
      // reload both running keys, chain and position stay
      key_hi_r <= cfg_wdata[KEY_W-1:HALF_W];
      rx_key_r <= cfg_wdata[HALF_W-1:0];
      tx_key_r <= cfg_wdata[HALF_W-1:0];
    end else if (advance) begin
      rx_key_r   <= rx_key_nxt;
      tx_key_r   <= tx_key_nxt;
      rx_chain_r <= rx_chain_nxt;
      tx_chain_r <= tx_chain_nxt;
      rx_pos_r   <= rx_pos_nxt;
      tx_pos_r   <= tx_pos_nxt;
      enabled_r  <= enabled_nxt;
      first_r    <= first_nxt;
    end
  end

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for rolling_xor_packet_cipher_unit
// predicts every result item from its own copy of the rx and tx cipher state
// depends on rxpc_pkg, rxpc_in_if, rxpc_out_if and the cipher unit itself
module tb_top;
  import rxpc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 28;
  localparam int HOLD_CYCLES = 60;
  localparam int PRINT_CAP   = 30;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [KEY_W-1:0] cfg_wdata;

  rxpc_in_if  in_ch ();
  rxpc_out_if out_ch ();

  rolling_xor_packet_cipher_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #2 clk = ~clk;

  // predicted cipher state, all zero out of reset
  logic [KEY_W-1:0]  sess_key     = '0;
  logic [HALF_W-1:0] rx_run_key   = '0;
  logic [HALF_W-1:0] tx_run_key   = '0;
  logic [7:0]        rx_prev      = '0;
  logic [7:0]        tx_prev      = '0;
  logic [POS_W-1:0]  rx_idx       = '0;
  logic [POS_W-1:0]  tx_idx       = '0;
  logic              link_enabled = 1'b0;
  logic              tx_plain_pkt = 1'b0;

  out_item_t predicted_bytes[$];
  int        mismatches     = 0;
  int        cycle_count    = 0;
  bit        calm           = 1'b0;   // no idling on either side while set
  int        stall_requests = 0;      // each bump asks the sink for one long hold

  // open packet per direction for the random traffic, indexed by opcode
  int          bytes_left[2] = '{0, 0};
  logic [15:0] len_field[2];

  // key byte at a packet position: low four from the running half, high four
  // from the session key
  function automatic logic [7:0] key_at(input logic [HALF_W-1:0] run,
                                        input logic [POS_W-1:0]  idx);
    logic [KEY_W-1:0] word;
    word = {sess_key[KEY_W-1:HALF_W], run};
    return word[{idx, 3'b000} +: 8];
  endfunction

  // expected result for one accepted item, advances the predicted state
  function automatic out_item_t transform_byte(input in_item_t it);
    out_item_t r;
    logic      fits;
    fits       = it.packet_length <= MAX_PACKET;
    r.out_byte = it.data_byte;
    r.out_last = it.last_byte;
    if (it.opcode == OP_ENCRYPT) begin
      // first outgoing packet switches the cipher on but itself goes out plain
      if (!link_enabled) begin
        link_enabled = 1'b1;
        tx_plain_pkt = 1'b1;
      end
      if (tx_plain_pkt) begin
        if (it.last_byte) begin
          tx_plain_pkt = 1'b0;
          tx_prev      = '0;
          tx_idx       = '0;
        end
      end else begin
        // oversize packets pass through, chain and position hold
        if (fits) begin
          r.out_byte = it.data_byte ^ key_at(tx_run_key, tx_idx) ^ tx_prev;
          tx_prev    = r.out_byte;
          tx_idx     = tx_idx + 1'b1;
        end
        // key advances by the stated length, even when oversize or mismatched
        if (it.last_byte) begin
          tx_run_key = tx_run_key + HALF_W'(it.packet_length);
          tx_prev    = '0;
          tx_idx     = '0;
        end
      end
    end else if (link_enabled) begin
      // decrypt chains on the incoming cipher byte, not on the result
      if (fits) begin
        r.out_byte = it.data_byte ^ key_at(rx_run_key, rx_idx) ^ rx_prev;
        rx_prev    = it.data_byte;
        rx_idx     = rx_idx + 1'b1;
      end
      if (it.last_byte) begin
        rx_run_key = rx_run_key + HALF_W'(it.packet_length);
        rx_prev    = '0;
        rx_idx     = '0;
      end
    end
    return r;
  endfunction

  function automatic in_item_t byte_item(input opcode_t op, input logic [7:0] data,
                                         input logic last, input logic [15:0] len);
    in_item_t it;
    it.opcode        = op;
    it.data_byte     = data;
    it.last_byte     = last;
    it.packet_length = len;
    return it;
  endfunction

  // offer one item after a random gap and wait for the handshake
  // called at a rising edge, returns at the edge of acceptance with valid still high
  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    predicted_bytes.push_back(transform_byte(it));
  endtask

  // sender pause: drop valid and wait until every predicted item came back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (predicted_bytes.size() != 0) @(posedge clk);
    // pipeline is two deep, the extra wait settles everything
    repeat (4) @(posedge clk);
  endtask

  // session key write, only ever with the unit idle
  task automatic load_session_key(input logic [KEY_W-1:0] k);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_we     <= 1'b0;
    sess_key   = k;
    rx_run_key = k[HALF_W-1:0];
    tx_run_key = k[HALF_W-1:0];
  endtask

  // random traffic: interleaved rx and tx packets with random content,
  // with a share of stray items that break the packet framing
  task automatic stream_packets(input int n_items, input int noise_pct);
    in_item_t it;
    int       dir;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(99) < noise_pct) begin
        it = byte_item(opcode_t'($urandom_range(1)), 8'($urandom_range(255)),
                       1'($urandom_range(1)), 16'($urandom_range(65535, 1)));
      end else begin
        dir = $urandom_range(1);
        if (bytes_left[dir] == 0) begin
          // mostly short packets, now and then past a full key cycle
          if ($urandom_range(9) == 0) begin
            bytes_left[dir] = $urandom_range(40, 1);
          end else begin
            bytes_left[dir] = $urandom_range(12, 1);
          end
          case ($urandom_range(19))
            0: len_field[dir] = MAX_PACKET;
            1: begin
              len_field[dir]  = MAX_PACKET + 16'd1;
              bytes_left[dir] = $urandom_range(4, 1);
            end
            2: begin
              len_field[dir]  = 16'hFFFF;
              bytes_left[dir] = $urandom_range(4, 1);
            end
            3: len_field[dir] = 16'($urandom_range(65535, 1));
            4: len_field[dir] = 16'(bytes_left[dir] + 1);
            default: len_field[dir] = 16'(bytes_left[dir]);
          endcase
        end
        it = byte_item(opcode_t'(dir), 8'($urandom_range(255)),
                       bytes_left[dir] == 1, len_field[dir]);
        bytes_left[dir]--;
      end
      send_item(it);
    end
  endtask

  // pass-through while disabled, first outgoing packet plain, enable mid-packet
  task automatic test_startup_passthrough();
    // incoming packet starts while the cipher is still off
    send_item(byte_item(OP_DECRYPT, 8'h00, 1'b0, 16'd5));
    send_item(byte_item(OP_DECRYPT, 8'hFF, 1'b0, 16'd5));
    send_item(byte_item(OP_DECRYPT, 8'h5A, 1'b0, 16'd5));
    // first outgoing packet goes out plain and turns the cipher on
    send_item(byte_item(OP_ENCRYPT, 8'hA5, 1'b0, 16'd2));
    send_item(byte_item(OP_ENCRYPT, 8'h3C, 1'b1, 16'd2));
    // rest of the incoming packet is now deciphered from position zero
    send_item(byte_item(OP_DECRYPT, 8'h12, 1'b0, 16'd5));
    send_item(byte_item(OP_DECRYPT, 8'hFE, 1'b1, 16'd5));
    // second outgoing packet is enciphered with the reset key
    send_item(byte_item(OP_ENCRYPT, 8'h00, 1'b0, 16'd3));
    send_item(byte_item(OP_ENCRYPT, 8'hFF, 1'b0, 16'd3));
    send_item(byte_item(OP_ENCRYPT, 8'h81, 1'b1, 16'd3));
  endtask

  // all-ones key, position wrap, size limit edges, key wrap, zero key
  task automatic test_key_extremes();
    load_session_key({KEY_W{1'b1}});
    // nine bytes take the position past the end of the key
    for (int k = 0; k < 9; k++) begin
      send_item(byte_item(OP_ENCRYPT, (k % 2) ? 8'hFF : 8'h00, k == 8, 16'd9));
    end
    // largest length that still fits, fewer bytes than stated
    send_item(byte_item(OP_DECRYPT, 8'hC3, 1'b0, MAX_PACKET));
    send_item(byte_item(OP_DECRYPT, 8'h3C, 1'b1, MAX_PACKET));
    // one past the limit passes through and still moves the key
    send_item(byte_item(OP_ENCRYPT, 8'h77, 1'b1, MAX_PACKET + 16'd1));
    // largest length moves the rx running key, already wrapped by the packet above
    send_item(byte_item(OP_DECRYPT, 8'h01, 1'b0, 16'hFFFF));
    send_item(byte_item(OP_DECRYPT, 8'h80, 1'b1, 16'hFFFF));
    load_session_key('0);
    send_item(byte_item(OP_ENCRYPT, 8'h9B, 1'b1, 16'd1));
  endtask

  // long random run over several keys, one stretch without idling
  task automatic test_random_packets();
    load_session_key({32'($urandom), 32'($urandom)});
    stream_packets(350, 10);
    load_session_key({KEY_W{1'b1}});
    calm = 1'b1;
    stream_packets(300, 10);
    calm = 1'b0;
    load_session_key('0);
    stream_packets(300, 15);
    load_session_key({32'($urandom), 32'($urandom)});
    stream_packets(350, 10);
  endtask

  // sink holds off while items keep coming, then a full sender pause
  task automatic test_backpressure();
    stall_requests++;
    stream_packets(80, 10);
    wait_drained();
    stream_packets(40, 10);
  endtask

  // result sink: random ready, or a long hold when one is requested
  initial begin : result_sink
    int hold_left;
    int served;
    hold_left = 0;
    served    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (served != stall_requests) begin
        served    = stall_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // compare each accepted result item with the oldest prediction
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
          $display("%0t: unexpected item, expected none, got byte %02h last %0b",
                   $time, out_ch.payload.out_byte, out_ch.payload.out_last);
        end
      end else begin
        want = predicted_bytes.pop_front();
        if (out_ch.payload.out_byte !== want.out_byte) begin
          mismatches++;
          if (mismatches <= PRINT_CAP) begin
            $display("%0t: out_byte expected %02h got %02h",
                     $time, want.out_byte, out_ch.payload.out_byte);
          end
        end
        if (out_ch.payload.out_last !== want.out_last) begin
          mismatches++;
          if (mismatches <= PRINT_CAP) begin
            $display("%0t: out_last expected %0b got %0b",
                     $time, want.out_last, out_ch.payload.out_last);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_startup_passthrough();
    test_key_extremes();
    test_random_packets();
    test_backpressure();

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/rxpc_pkg.sv
hdl/rxpc_in_if.sv
hdl/rxpc_out_if.sv
hdl/rolling_xor_packet_cipher_unit.sv
tb/tb_top.sv
